[sv/mafl_pkg.sv]
package mafl_pkg;

    // Table depth used when the top level is not overridden
    localparam int unsigned DEF_MAX_ENTRIES = 1024;

    localparam int unsigned ADDR_W  = 32;
    localparam int unsigned OCTET_W = 8;
    localparam logic [OCTET_W-1:0] OCTET_ALL = 8'hFF;

    // Transaction modes
    localparam logic [1:0] MODE_LOOKUP = 2'd0;
    localparam logic [1:0] MODE_ADD    = 2'd1;
    localparam logic [1:0] MODE_REMOVE = 2'd2;

    // Result status codes
    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_FULL    = 2'd1,
        ST_DUP     = 2'd2,
        ST_MISSING = 2'd3
    } status_t;

    // Octet mask of a compare value: all ones for each nonzero octet
    function automatic logic [ADDR_W-1:0] mask_of(input logic [ADDR_W-1:0] v);
        logic [ADDR_W-1:0] m;
        m = '0;
        for (int k = 0; k < ADDR_W / OCTET_W; k++) begin
            if (v[k*OCTET_W +: OCTET_W] != '0) begin
                m[k*OCTET_W +: OCTET_W] = OCTET_ALL;
            end
        end
        return m;
    endfunction

endpackage

[sv/mafl_match.sv]
module mafl_match
    import mafl_pkg::*;
(
    input  logic              lookup,
    input  logic [ADDR_W-1:0] address,
    input  logic [ADDR_W-1:0] entry,
    output logic              hit
);

    // Lookup compares under the entry's octet mask; add/remove want an exact value
    always_comb begin
        if (lookup) begin
            hit = ((address & mask_of(entry)) == entry);
        end else begin
            hit = (entry == address);
        end
    end

endmodule

[sv/masked_address_filter_table_unit.sv]
// Masked IPv4 address filter table.
// Input channel (s_valid/s_ready, s_mode, s_address) carries one transaction:
// lookup, add entry or remove entry. Result channel (m_valid/m_ready) returns
// exactly one result per transaction: m_permit, m_status, m_entry_count.
// Configuration channel (cfg_valid/cfg_ready, cfg_ban_mode) sets the ban mode;
// it is always ready; the user must write it only while the unit is idle,
// which the block does not enforce. Entries live in a single-port-read
// synchronous RAM. Lookup, duplicate check and remove scan the stored
// entries one read per cycle and stop at the first hit. Remove of a non-last
// entry then moves the last entry into the freed slot through the S_MOVE_RD
// and S_MOVE_WR states. A full-table add skips the scan and goes straight
// to the result step.
// One transaction is worked on at a time; the next is accepted as soon as the
// previous result is in the output register, even if it is not yet taken.
// When the receiver stalls, the result holds in the output register and the
// following transaction waits at its result step until the register frees.
// Reset (aresetn low, synchronous) empties the table and sets ban mode to 1;
// the RAM contents are not cleared and no clearing pass is needed.
module masked_address_filter_table_unit
    import mafl_pkg::*;
#(
    parameter int unsigned MAX_ENTRIES = DEF_MAX_ENTRIES,
    localparam int unsigned CNT_W = $clog2(MAX_ENTRIES + 1),
    localparam int unsigned IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1
) (
    input  logic              aclk,
    input  logic              aresetn,

    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic              cfg_ban_mode,

    input  logic              s_valid,
    output logic              s_ready,
    input  logic [1:0]        s_mode,
    input  logic [ADDR_W-1:0] s_address,

    output logic              m_valid,
    input  logic              m_ready,
    output logic              m_permit,
    output logic [1:0]        m_status,
    output logic [CNT_W-1:0]  m_entry_count
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_MOVE_RD,
        S_MOVE_WR,
        S_RESULT
    } state_t;

    state_t            state_reg;
    logic [1:0]        mode_reg;
    logic [ADDR_W-1:0] addr_reg;
    logic [CNT_W-1:0]  idx_reg;
    logic              cmp_valid_reg;
    logic [IDX_W-1:0]  cmp_idx_reg;
    logic [IDX_W-1:0]  hit_idx_reg;
    logic [CNT_W-1:0]  count_reg;
    logic              ban_reg;
    logic              res_permit_reg;
    status_t           res_status_reg;
    logic              m_valid_reg;
    logic              m_permit_reg;
    status_t           m_status_reg;
    logic [CNT_W-1:0]  m_count_reg;

    // Filter RAM
    logic [ADDR_W-1:0] mem [MAX_ENTRIES];
    logic [ADDR_W-1:0] rd_data_reg;
    logic [IDX_W-1:0]  mem_ra;
    logic              mem_we;
    logic [IDX_W-1:0]  mem_wa;
    logic [ADDR_W-1:0] mem_wd;

    logic [CNT_W-1:0]  count_dec;
    logic [IDX_W-1:0]  last_idx;
    logic              entry_hit;
    logic              scan_hit;
    logic              scan_done;
    logic              issue;
    logic              add_commit;
    logic              move_commit;
    logic              out_free;

    assign cfg_ready     = 1'b1;
    assign s_ready       = (state_reg == S_IDLE);
    assign m_valid       = m_valid_reg;
    assign m_permit      = m_permit_reg;
    assign m_status      = m_status_reg;
    assign m_entry_count = m_count_reg;

    assign count_dec = count_reg - CNT_W'(1);
    assign last_idx  = count_dec[IDX_W-1:0];
    assign out_free  = !m_valid_reg || m_ready;

    // Entry compare on the RAM read data
    mafl_match u_match (
        .lookup  (mode_reg == MODE_LOOKUP),
        .address (addr_reg),
        .entry   (rd_data_reg),
        .hit     (entry_hit)
    );

    // Scan control: read data of the previous cycle is compared this cycle
    assign scan_hit  = cmp_valid_reg && entry_hit;
    assign scan_done = scan_hit || (cmp_valid_reg && cmp_idx_reg == last_idx)
                       || (count_reg == '0);
    assign issue     = (state_reg == S_SCAN) && (idx_reg < count_reg) && !scan_done;

    // RAM access selection
    assign add_commit  = (state_reg == S_SCAN) && scan_done && !scan_hit
                         && (mode_reg == MODE_ADD);
    assign move_commit = (state_reg == S_MOVE_WR);

    always_comb begin
        mem_ra = idx_reg[IDX_W-1:0];
        if (state_reg == S_MOVE_RD) begin
            mem_ra = last_idx;
        end
        mem_we = add_commit || move_commit;
        mem_wa = move_commit ? hit_idx_reg : count_reg[IDX_W-1:0];
        mem_wd = move_commit ? rd_data_reg : addr_reg;
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_wa] <= mem_wd;
        end
        rd_data_reg <= mem[mem_ra];
    end

    // Control state machine and output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            ban_reg       <= 1'b1;
            m_valid_reg   <= 1'b0;
            cmp_valid_reg <= 1'b0;
        end else begin
            if (cfg_valid) begin
                ban_reg <= cfg_ban_mode;
            end
            // output valid: load at the result step, clear once taken
            if (state_reg == S_RESULT && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end

            case (state_reg)
                S_IDLE: begin
                    if (s_valid) begin
                        mode_reg       <= s_mode;
                        addr_reg       <= s_address;
                        idx_reg        <= '0;
                        cmp_valid_reg  <= 1'b0;
                        res_permit_reg <= 1'b0;
                        res_status_reg <= (s_mode == MODE_ADD &&
                                           count_reg == CNT_W'(MAX_ENTRIES)) ?
                                          ST_FULL : ST_OK;
                        case (s_mode)
                            MODE_LOOKUP, MODE_REMOVE: begin
                                state_reg <= S_SCAN;
                            end
                            MODE_ADD: begin
                                if (count_reg == CNT_W'(MAX_ENTRIES)) begin
                                    state_reg <= S_RESULT;
                                end else begin
                                    state_reg <= S_SCAN;
                                end
                            end
                            default: begin
                                state_reg <= S_RESULT;
                            end
                        endcase
                    end
                end

                S_SCAN: begin
                    cmp_valid_reg <= issue;
                    if (issue) begin
                        idx_reg     <= idx_reg + CNT_W'(1);
                        cmp_idx_reg <= idx_reg[IDX_W-1:0];
                    end
                    if (scan_done) begin
                        // a hit before the last entry needs the move steps
                        if (mode_reg == MODE_REMOVE && scan_hit &&
                            cmp_idx_reg != last_idx) begin
                            state_reg <= S_MOVE_RD;
                        end else begin
                            state_reg <= S_RESULT;
                        end
                        case (mode_reg)
                            MODE_LOOKUP: begin
                                res_permit_reg <= scan_hit ? !ban_reg : ban_reg;
                            end
                            MODE_ADD: begin
                                if (scan_hit) begin
                                    res_status_reg <= ST_DUP;
                                end else begin
                                    count_reg <= count_reg + CNT_W'(1);
                                end
                            end
                            MODE_REMOVE: begin
                                if (!scan_hit) begin
                                    res_status_reg <= ST_MISSING;
                                end else if (cmp_idx_reg == last_idx) begin
                                    count_reg <= count_dec;
                                end else begin
                                    // fill the hole with the last entry
                                    hit_idx_reg <= cmp_idx_reg;
                                end
                            end
                            default: begin
                                res_status_reg <= ST_OK;
                            end
                        endcase
                    end
                end

                S_MOVE_RD: begin
                    state_reg <= S_MOVE_WR;
                end

                S_MOVE_WR: begin
                    count_reg <= count_dec;
                    state_reg <= S_RESULT;
                end

                S_RESULT: begin
                    if (out_free) begin
                        m_permit_reg <= res_permit_reg;
                        m_status_reg <= res_status_reg;
                        m_count_reg  <= count_reg;
                        state_reg    <= S_IDLE;
                    end
                end

                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // Checks
    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(MAX_ENTRIES))
        else $error("entry count beyond table depth");

    a_count_step: assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg != $past(count_reg) && $past(aresetn)) |->
        (count_reg == $past(count_reg) + CNT_W'(1) ||
         count_reg == $past(count_reg) - CNT_W'(1)))
        else $error("entry count moved by more than one");

    a_write_source: assert property (@(posedge aclk) disable iff (!aresetn)
        mem_we |-> ((state_reg == S_SCAN && mode_reg == MODE_ADD) ||
                    state_reg == S_MOVE_WR))
        else $error("table write outside add or move");

    a_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("new transaction taken while one is in progress");

    a_result_load: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_RESULT && out_free) |=> m_valid)
        else $error("result not presented after result step");

endmodule

[dv/masked_address_filter_table_unit_tb.sv]
`timescale 1ns / 100ps

module masked_address_filter_table_unit_tb;
    import mafl_pkg::*;

    localparam int unsigned TABLE_DEPTH = DEF_MAX_ENTRIES;
    localparam int unsigned CNT_W       = $clog2(TABLE_DEPTH + 1);
    localparam time         CLK_PERIOD  = 12ns;
    localparam logic [1:0]  MODE_UNUSED = 2'd3;

    // One expected result transaction
    typedef struct packed {
        logic             permit;
        status_t          status;
        logic [CNT_W-1:0] entry_count;
    } verdict_t;

    logic              aclk = 1'b0;
    logic              aresetn = 1'b0;
    logic              cfg_valid = 1'b0;
    logic              cfg_ready;
    logic              cfg_ban_mode = 1'b0;
    logic              s_valid = 1'b0;
    logic              s_ready;
    logic [1:0]        s_mode = MODE_LOOKUP;
    logic [ADDR_W-1:0] s_address = '0;
    logic              m_valid;
    logic              m_ready = 1'b0;
    logic              m_permit;
    logic [1:0]        m_status;
    logic [CNT_W-1:0]  m_entry_count;

    // Shadow of the filter table and the ban setting
    logic [ADDR_W-1:0] filter_entries[$];
    logic              ban_setting = 1'b1;
    verdict_t          expected_verdicts[$];
    verdict_t          head_verdict;

    bit                src_gaps = 1'b1;
    bit                sink_gaps = 1'b1;
    int unsigned       fault_count = 0;
    int unsigned       checked_count = 0;
    int unsigned       ban_writes = 0;
    int unsigned       peak_entries = 0;
    int unsigned       mode_seen[4];

    masked_address_filter_table_unit #(
        .MAX_ENTRIES(TABLE_DEPTH)
    ) u_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_ban_mode  (cfg_ban_mode),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_mode        (s_mode),
        .s_address     (s_address),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_permit      (m_permit),
        .m_status      (m_status),
        .m_entry_count (m_entry_count)
    );

    always #(CLK_PERIOD / 2) aclk = ~aclk;

    // Mask with 0xFF for each nonzero octet of the compare value
    function automatic logic [ADDR_W-1:0] octet_mask(input logic [ADDR_W-1:0] value);
        logic [ADDR_W-1:0] m;
        m = '0;
        for (int k = 0; k < ADDR_W / 8; k++) begin
            if (|value[8*k +: 8]) m[8*k +: 8] = 8'hFF;
        end
        return m;
    endfunction

    function automatic int find_entry(input logic [ADDR_W-1:0] value);
        foreach (filter_entries[i]) begin
            if (filter_entries[i] == value) return i;
        end
        return -1;
    endfunction

    // Applies one transaction to the shadow table and returns its verdict
    function automatic verdict_t predict_verdict(input logic [1:0] mode,
                                                 input logic [ADDR_W-1:0] addr);
        verdict_t v;
        int       pos;
        v.permit = 1'b0;
        v.status = ST_OK;
        case (mode)
            MODE_LOOKUP: begin
                v.permit = ban_setting;
                foreach (filter_entries[i]) begin
                    if ((addr & octet_mask(filter_entries[i])) == filter_entries[i])
                        v.permit = ~ban_setting;
                end
            end
            MODE_ADD: begin
                // full is reported ahead of duplicate
                if (filter_entries.size() >= TABLE_DEPTH) v.status = ST_FULL;
                else if (find_entry(addr) >= 0) v.status = ST_DUP;
                else filter_entries.push_back(addr);
            end
            MODE_REMOVE: begin
                pos = find_entry(addr);
                if (pos < 0) v.status = ST_MISSING;
                else filter_entries.delete(pos);
            end
            default: ;
        endcase
        v.entry_count = CNT_W'(filter_entries.size());
        return v;
    endfunction

    // Random filter value, octets zeroed now and then to widen the mask mix
    function automatic logic [ADDR_W-1:0] rand_filter_value();
        logic [ADDR_W-1:0] v;
        v = $urandom;
        for (int k = 0; k < ADDR_W / 8; k++) begin
            if ($urandom_range(0, 3) == 0) v[8*k +: 8] = 8'h00;
        end
        if ($urandom_range(0, 63) == 0) v = '0;
        return v;
    endfunction

    // Send one transaction; prediction is made at the accepting edge
    task automatic issue_transaction(input logic [1:0] mode, input logic [ADDR_W-1:0] addr);
        verdict_t v;
        if (src_gaps && $urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_mode    <= mode;
        s_address <= addr;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        v = predict_verdict(mode, addr);
        expected_verdicts.push_back(v);
        mode_seen[mode]++;
        if (filter_entries.size() > peak_entries) peak_entries = filter_entries.size();
    endtask

    // Hold off the sender until every outstanding result is back
    task automatic drain_results();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (expected_verdicts.size() != 0) @(posedge aclk);
    endtask

    task automatic write_ban_mode(input logic value);
        drain_results();
        cfg_valid    <= 1'b1;
        cfg_ban_mode <= value;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        ban_setting = value;
        ban_writes++;
        cfg_valid <= 1'b0;
    endtask

    // Operations, field extremes, zero entry, duplicate, not found, unused mode
    task automatic test_directed_cases();
        issue_transaction(MODE_LOOKUP, 32'hC0A8_0101);
        issue_transaction(MODE_REMOVE, 32'hC0A8_0000);
        issue_transaction(MODE_UNUSED, 32'hFFFF_FFFF);
        issue_transaction(MODE_ADD,    32'hC0A8_0000);
        issue_transaction(MODE_ADD,    32'hC0A8_0000);
        issue_transaction(MODE_LOOKUP, 32'hC0A8_FE07);
        issue_transaction(MODE_LOOKUP, 32'hC0A9_0000);
        issue_transaction(MODE_ADD,    32'hFFFF_FFFF);
        issue_transaction(MODE_LOOKUP, 32'hFFFF_FFFF);
        issue_transaction(MODE_LOOKUP, 32'h0000_0000);
        issue_transaction(MODE_ADD,    32'h0A00_0001);
        issue_transaction(MODE_LOOKUP, 32'h0A7F_3301);
        issue_transaction(MODE_LOOKUP, 32'h0B7F_3301);
        // all-zero entry matches everything
        issue_transaction(MODE_ADD,    32'h0000_0000);
        issue_transaction(MODE_LOOKUP, 32'h1234_5678);
        issue_transaction(MODE_LOOKUP, 32'h0000_0000);
        issue_transaction(MODE_UNUSED, 32'h0000_0000);
        issue_transaction(MODE_REMOVE, 32'h0000_0000);
        issue_transaction(MODE_REMOVE, 32'h0000_0000);
        issue_transaction(MODE_REMOVE, 32'hC0A8_0000);
        issue_transaction(MODE_REMOVE, 32'hFFFF_FFFF);
        issue_transaction(MODE_REMOVE, 32'h0A00_0001);
        issue_transaction(MODE_LOOKUP, 32'h0A00_0001);
    endtask

    // Verdict under both ban settings, with and without a match
    task automatic test_ban_mode();
        write_ban_mode(1'b0);
        issue_transaction(MODE_LOOKUP, 32'h0A01_0203);
        issue_transaction(MODE_ADD,    32'h0A00_0000);
        issue_transaction(MODE_LOOKUP, 32'h0A01_0203);
        issue_transaction(MODE_LOOKUP, 32'h0B00_0000);
        write_ban_mode(1'b1);
        issue_transaction(MODE_LOOKUP, 32'h0A01_0203);
        issue_transaction(MODE_LOOKUP, 32'h0B00_0000);
        write_ban_mode(1'b0);
        issue_transaction(MODE_REMOVE, 32'h0A00_0000);
        issue_transaction(MODE_LOOKUP, 32'h0A01_0203);
    endtask

    // Mostly table-aware traffic with random content, some noise
    task automatic test_random_traffic();
        int                sel;
        int                occupancy;
        logic [ADDR_W-1:0] pick;
        for (int phase = 0; phase < 5; phase++) begin
            src_gaps  = (phase != 2 && phase != 3);
            sink_gaps = (phase != 1 && phase != 3);
            write_ban_mode((phase % 2) == 0);
            for (int n = 0; n < 100; n++) begin
                sel       = $urandom_range(0, 99);
                occupancy = filter_entries.size();
                pick      = (occupancy > 0) ?
                            filter_entries[$urandom_range(0, occupancy - 1)] : '0;
                if (sel < 40) begin
                    // half the lookups are built to hit a stored entry
                    if (occupancy > 0 && $urandom_range(0, 1) == 1)
                        issue_transaction(MODE_LOOKUP, pick | ($urandom & ~octet_mask(pick)));
                    else
                        issue_transaction(MODE_LOOKUP, $urandom);
                end else if (sel < 70 && occupancy < 48) begin
                    if (occupancy > 0 && $urandom_range(0, 5) == 0)
                        issue_transaction(MODE_ADD, pick);
                    else
                        issue_transaction(MODE_ADD, rand_filter_value());
                end else if (sel < 97) begin
                    if (occupancy > 0 && $urandom_range(0, 9) < 7)
                        issue_transaction(MODE_REMOVE, pick);
                    else
                        issue_transaction(MODE_REMOVE, rand_filter_value());
                end else begin
                    issue_transaction(MODE_UNUSED, $urandom);
                end
                if ($urandom_range(0, 63) == 0) drain_results();
            end
        end
    endtask

    // Fill to depth, then overflow, duplicate at full, and churn at the top
    task automatic test_table_full();
        int unsigned k;
        src_gaps  = 1'b0;
        sink_gaps = 1'b0;
        write_ban_mode(1'b1);
        k = 0;
        while (filter_entries.size() < TABLE_DEPTH) begin
            issue_transaction(MODE_ADD, 32'hAC10_0101 + (k << 8));
            k++;
        end
        issue_transaction(MODE_ADD,    32'h0102_0304);
        issue_transaction(MODE_ADD,    filter_entries[0]);
        issue_transaction(MODE_LOOKUP, 32'hAC10_0101);
        issue_transaction(MODE_LOOKUP, 32'h0102_0304);
        issue_transaction(MODE_REMOVE, filter_entries[TABLE_DEPTH - 1]);
        issue_transaction(MODE_ADD,    filter_entries[0]);
        issue_transaction(MODE_ADD,    32'h0102_0304);
        issue_transaction(MODE_REMOVE, 32'h0505_0505);
        issue_transaction(MODE_UNUSED, 32'h5A5A_A5A5);
    endtask

    // Receiver stalls in random bursts
    initial begin : sink_pacing
        forever begin
            @(posedge aclk);
            if (sink_gaps && $urandom_range(0, 7) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 17)) @(posedge aclk);
            end
            m_ready <= 1'b1;
        end
    end

    // Compare each result transaction with the oldest prediction
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (expected_verdicts.size() == 0) begin
                $error("unexpected result: permit %0d status %0d entry_count %0d",
                       m_permit, m_status, m_entry_count);
                fault_count++;
            end else begin
                head_verdict = expected_verdicts.pop_front();
                checked_count++;
                if (m_permit !== head_verdict.permit) begin
                    $error("permit: expected %0d, got %0d", head_verdict.permit, m_permit);
                    fault_count++;
                end
                if (m_status !== head_verdict.status) begin
                    $error("status: expected %0d, got %0d", head_verdict.status, m_status);
                    fault_count++;
                end
                if (m_entry_count !== head_verdict.entry_count) begin
                    $error("entry_count: expected %0d, got %0d",
                           head_verdict.entry_count, m_entry_count);
                    fault_count++;
                end
            end
        end
    end

    initial begin : watchdog
        #100ms;
        $display("RESULT: ERROR");
        $finish;
    end

    initial begin : main_sequence
        int unsigned guard;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed_cases();
        test_ban_mode();
        test_random_traffic();
        test_table_full();

        // wind down: collect what is outstanding, then watch for strays
        s_valid <= 1'b0;
        guard = 0;
        @(posedge aclk);
        while (expected_verdicts.size() != 0 && guard < 20000) begin
            @(posedge aclk);
            guard++;
        end
        if (expected_verdicts.size() != 0) begin
            $error("%0d results never arrived", expected_verdicts.size());
            fault_count++;
        end
        repeat (TABLE_DEPTH + 16) @(posedge aclk);

        $display("Covered %0d lookups, %0d adds, %0d removes, %0d unused-mode transactions;",
                 mode_seen[MODE_LOOKUP], mode_seen[MODE_ADD], mode_seen[MODE_REMOVE],
                 mode_seen[MODE_UNUSED]);
        $display("%0d results checked, %0d ban mode writes, table peaked at %0d of %0d entries.",
                 checked_count, ban_writes, peak_entries, TABLE_DEPTH);
        if (fault_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
